// File: hdl/ctbr_pkg.sv
// Shared types and constants of the counter timebase rescaler.
package ctbr_pkg;

  localparam int unsigned COUNTER_W = 63;
  localparam int unsigned DELTA_W   = 64;
  localparam int unsigned FREQ_W    = 41;
  localparam int unsigned RATE_W    = 20;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned PROD_W    = FREQ_W + RATE_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 63;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN    = 2'd0,
    CFG_FREQUENCY = 2'd1,
    CFG_RATE      = 2'd2
  } cfg_index_t;

  localparam logic [RATE_W-1:0] RATE_LOW     = 20'd1000;
  localparam logic [RATE_W-1:0] RATE_HIGH    = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_RESET   = 20'd100000;
  localparam logic [FREQ_W-1:0] FREQ_DEFAULT = 41'd10000000;

endpackage

// File: hdl/counter_timebase_rescaler.sv
// Counter timebase rescaler: pipelined conversion of counter samples to ticks.
//
// A sample transaction (sample_valid/sample_stall) carries counter_value,
// counter_valid and fallback_ms. Each one yields exactly one tick transaction
// (tick_valid/tick_stall) carrying tick_count, in the order taken. The origin
// is subtracted modulo 2^64 and the difference is rescaled from the counter
// frequency to the tick rate as (delta / f) * rate + ((delta % f) * rate) / f,
// truncated to 32 bits. A bad sample or a zero frequency returns fallback_ms.
// The pipeline has one subtract stage, 64 restoring-divider stages of
// one quotient bit each, one multiply stage, 20 divider stages for the
// fractional part and one output register. One sample is taken every cycle
// unless stalled: a stalled output result freezes the whole pipeline, and
// sample_stall is raised in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the default origin, frequency and
// rate. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
// once; the user must make them only while no sample is in flight, which is
// not enforced. Out-of-range rates become 100000; unknown indexes are ignored.
module counter_timebase_rescaler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ctbr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctbr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [ctbr_pkg::COUNTER_W-1:0]      counter_value,
  input  logic                                counter_valid,
  input  logic [ctbr_pkg::TICK_W-1:0]         fallback_ms,
  output logic                                tick_valid,
  input  logic                                tick_stall,
  output logic [ctbr_pkg::TICK_W-1:0]         tick_count
);

  localparam int unsigned DIV1_STEPS = ctbr_pkg::DELTA_W;
  localparam int unsigned DIV2_STEPS = ctbr_pkg::RATE_W;

  // Configuration registers.
  logic [ctbr_pkg::COUNTER_W-1:0] origin;
  logic [ctbr_pkg::FREQ_W-1:0]    frequency;
  logic [ctbr_pkg::RATE_W-1:0]    rate;
  logic [ctbr_pkg::RATE_W-1:0]    rate_next;

  logic advance;

  // Subtract stage.
  logic                          s0_valid;
  logic                          s0_bypass;
  logic [ctbr_pkg::DELTA_W-1:0]  s0_delta;
  logic [ctbr_pkg::TICK_W-1:0]   s0_fallback;

  // Integer-part divider stages.
  logic [DIV1_STEPS-1:0]          d1_valid;
  logic [DIV1_STEPS-1:0]          d1_bypass;
  logic [ctbr_pkg::TICK_W-1:0]    d1_fallback [DIV1_STEPS];
  logic [ctbr_pkg::FREQ_W-1:0]    d1_rem      [DIV1_STEPS];
  logic [ctbr_pkg::DELTA_W-1:0]   d1_num      [DIV1_STEPS];
  logic [ctbr_pkg::FREQ_W:0]      d1_trial    [DIV1_STEPS];
  logic [ctbr_pkg::FREQ_W-1:0]    d1_rem_next [DIV1_STEPS];
  logic [ctbr_pkg::DELTA_W-1:0]   d1_num_next [DIV1_STEPS];

  // Multiply stage.
  logic                                     m_valid;
  logic                                     m_bypass;
  logic [ctbr_pkg::TICK_W-1:0]              m_fallback;
  logic [ctbr_pkg::PROD_W-1:0]              m_prod;
  logic [ctbr_pkg::TICK_W-1:0]              m_whole;
  logic [ctbr_pkg::PROD_W-1:0]              m_prod_next;
  logic [ctbr_pkg::TICK_W+ctbr_pkg::RATE_W-1:0] m_whole_full;

  // Fractional-part divider stages.
  logic [DIV2_STEPS-1:0]          d2_valid;
  logic [DIV2_STEPS-1:0]          d2_bypass;
  logic [ctbr_pkg::TICK_W-1:0]    d2_fallback [DIV2_STEPS];
  logic [ctbr_pkg::TICK_W-1:0]    d2_whole    [DIV2_STEPS];
  logic [ctbr_pkg::FREQ_W-1:0]    d2_rem      [DIV2_STEPS];
  logic [DIV2_STEPS-1:0]          d2_num      [DIV2_STEPS];
  logic [ctbr_pkg::FREQ_W:0]      d2_trial    [DIV2_STEPS];
  logic [ctbr_pkg::FREQ_W-1:0]    d2_rem_next [DIV2_STEPS];
  logic [DIV2_STEPS-1:0]          d2_num_next [DIV2_STEPS];

  // The whole pipeline moves together unless a finished result is held.
  assign advance      = !(tick_valid && tick_stall);
  assign sample_stall = !advance;

  always_comb begin
    rate_next = cfg_data[ctbr_pkg::RATE_W-1:0];
    if (rate_next < ctbr_pkg::RATE_LOW || rate_next > ctbr_pkg::RATE_HIGH) begin
      rate_next = ctbr_pkg::RATE_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin    <= '0;
      frequency <= ctbr_pkg::FREQ_DEFAULT;
      rate      <= ctbr_pkg::RATE_RESET;
    end else if (cfg_we) begin
      case (ctbr_pkg::cfg_index_t'(cfg_index))
        ctbr_pkg::CFG_ORIGIN:    origin    <= cfg_data;
        ctbr_pkg::CFG_FREQUENCY: frequency <= cfg_data[ctbr_pkg::FREQ_W-1:0];
        ctbr_pkg::CFG_RATE:      rate      <= rate_next;
        default: ;
      endcase
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      d1_valid   <= '0;
      m_valid    <= 1'b0;
      d2_valid   <= '0;
      tick_valid <= 1'b0;
    end else if (advance) begin
      s0_valid   <= sample_valid;
      d1_valid   <= {d1_valid[DIV1_STEPS-2:0], s0_valid};
      m_valid    <= d1_valid[DIV1_STEPS-1];
      d2_valid   <= {d2_valid[DIV2_STEPS-2:0], m_valid};
      tick_valid <= d2_valid[DIV2_STEPS-1];
    end
  end

  // Each divider stage makes one quotient bit; the dividend shifts out of the
  // top of the number register while quotient bits shift in at the bottom.
  always_comb begin
    d1_trial[0]    = {{ctbr_pkg::FREQ_W{1'b0}}, s0_delta[ctbr_pkg::DELTA_W-1]};
    d1_num_next[0] = {s0_delta[ctbr_pkg::DELTA_W-2:0], 1'b0};
    for (int k = 1; k < DIV1_STEPS; k++) begin
      d1_trial[k]    = {d1_rem[k-1], d1_num[k-1][ctbr_pkg::DELTA_W-1]};
      d1_num_next[k] = {d1_num[k-1][ctbr_pkg::DELTA_W-2:0], 1'b0};
    end
    for (int k = 0; k < DIV1_STEPS; k++) begin
      if (d1_trial[k] >= {1'b0, frequency}) begin
        d1_rem_next[k]    = ctbr_pkg::FREQ_W'(d1_trial[k] - {1'b0, frequency});
        d1_num_next[k][0] = 1'b1;
      end else begin
        d1_rem_next[k] = d1_trial[k][ctbr_pkg::FREQ_W-1:0];
      end
    end
  end

  // The product remainder * rate stays below f * 2^20, so its upper bits
  // already form a partial remainder below f and 20 steps suffice.
  always_comb begin
    d2_trial[0]    = {m_prod[ctbr_pkg::PROD_W-1:DIV2_STEPS], m_prod[DIV2_STEPS-1]};
    d2_num_next[0] = {m_prod[DIV2_STEPS-2:0], 1'b0};
    for (int k = 1; k < DIV2_STEPS; k++) begin
      d2_trial[k]    = {d2_rem[k-1], d2_num[k-1][DIV2_STEPS-1]};
      d2_num_next[k] = {d2_num[k-1][DIV2_STEPS-2:0], 1'b0};
    end
    for (int k = 0; k < DIV2_STEPS; k++) begin
      if (d2_trial[k] >= {1'b0, frequency}) begin
        d2_rem_next[k]    = ctbr_pkg::FREQ_W'(d2_trial[k] - {1'b0, frequency});
        d2_num_next[k][0] = 1'b1;
      end else begin
        d2_rem_next[k] = d2_trial[k][ctbr_pkg::FREQ_W-1:0];
      end
    end
  end

  // Only the low 32 bits of the whole part survive the final truncation.
  assign m_prod_next  = d1_rem[DIV1_STEPS-1] * rate;
  assign m_whole_full = d1_num[DIV1_STEPS-1][ctbr_pkg::TICK_W-1:0] * rate;

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_delta    <= {1'b0, counter_value} - {1'b0, origin};
      s0_bypass   <= !counter_valid || (frequency == '0);
      s0_fallback <= fallback_ms;

      d1_bypass      <= {d1_bypass[DIV1_STEPS-2:0], s0_bypass};
      d1_fallback[0] <= s0_fallback;
      for (int k = 1; k < DIV1_STEPS; k++) begin
        d1_fallback[k] <= d1_fallback[k-1];
      end
      for (int k = 0; k < DIV1_STEPS; k++) begin
        d1_rem[k] <= d1_rem_next[k];
        d1_num[k] <= d1_num_next[k];
      end

      m_bypass   <= d1_bypass[DIV1_STEPS-1];
      m_fallback <= d1_fallback[DIV1_STEPS-1];
      m_prod     <= m_prod_next;
      m_whole    <= m_whole_full[ctbr_pkg::TICK_W-1:0];

      d2_bypass      <= {d2_bypass[DIV2_STEPS-2:0], m_bypass};
      d2_fallback[0] <= m_fallback;
      d2_whole[0]    <= m_whole;
      for (int k = 1; k < DIV2_STEPS; k++) begin
        d2_fallback[k] <= d2_fallback[k-1];
        d2_whole[k]    <= d2_whole[k-1];
      end
      for (int k = 0; k < DIV2_STEPS; k++) begin
        d2_rem[k] <= d2_rem_next[k];
        d2_num[k] <= d2_num_next[k];
      end

      if (d2_bypass[DIV2_STEPS-1]) begin
        tick_count <= d2_fallback[DIV2_STEPS-1];
      end else begin
        tick_count <= d2_whole[DIV2_STEPS-1]
                      + ctbr_pkg::TICK_W'(d2_num[DIV2_STEPS-1]);
      end
    end
  end

endmodule
